@@ rtl/lvpm_pkg.sv @@
// Shared types and codes for the virtual light mapper.
package lvpm_pkg;

  localparam int ADDR_W = 24;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] KIND_COLOR = 2'd0;
  localparam logic [1:0] KIND_ONE   = 2'd1;
  localparam logic [1:0] KIND_MORE  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [4:0] dp_op_t;

  localparam dp_op_t OP_NONE      = 5'd0;
  localparam dp_op_t OP_LOAD      = 5'd1;
  localparam dp_op_t OP_INIT_STEP = 5'd2;
  localparam dp_op_t OP_CLR_START = 5'd3;
  localparam dp_op_t OP_CLR_STEP  = 5'd4;
  localparam dp_op_t OP_ENT_RD    = 5'd5;
  localparam dp_op_t OP_ADD_COLOR = 5'd6;
  localparam dp_op_t OP_ADD_NEW1  = 5'd7;
  localparam dp_op_t OP_ADD_NEW2  = 5'd8;
  localparam dp_op_t OP_HT_RD     = 5'd9;
  localparam dp_op_t OP_ADD_APP1  = 5'd10;
  localparam dp_op_t OP_ADD_APP2  = 5'd11;
  localparam dp_op_t OP_COLOR_WR  = 5'd12;
  localparam dp_op_t OP_COLOR_RD  = 5'd13;
  localparam dp_op_t OP_PTR_HEAD  = 5'd14;
  localparam dp_op_t OP_POOL_RD   = 5'd15;
  localparam dp_op_t OP_LIGHT_V   = 5'd16;
  localparam dp_op_t OP_LIGHT_VAL = 5'd17;
  localparam dp_op_t OP_LIGHT_PL  = 5'd18;
  localparam dp_op_t OP_MUL       = 5'd19;
  localparam dp_op_t OP_ADDR      = 5'd20;
  localparam dp_op_t OP_CHK       = 5'd21;
  localparam dp_op_t OP_WBYTE     = 5'd22;
  localparam dp_op_t OP_RBYTE     = 5'd23;
  localparam dp_op_t OP_NEXT      = 5'd24;

  typedef struct packed {
    dp_op_t     op;
    logic       fin;
    logic [1:0] fin_status;
  } dp_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       init_done;
    logic       clr_done;
    logic [1:0] cmd;
    logic       v_range;
    logic       cnt_bad;
    logic       mapped;
    logic [1:0] kind;
    logic       full_new;
    logic       full_app;
    logic       oob;
    logic       wr_last;
    logic       rd_last;
    logic       at_tail;
    logic       list_mode;
  } dp_stat_t;

endpackage

@@ rtl/led_virtual_pixel_mapper_top.sv @@
// Top level of the virtual light mapper: controller and datapath.
//
//   channel  direction  payload
//   in_      slave      tuser: command; tdata: virtual, physical, offset, count, bytes 0-3
//   out_     master     tuser: status; tdata: read bytes 0-2
//   cfg_     slave      tdata: channels per light
//
// One request is taken at a time: a clear steps through every map entry, and a write or read
// to one light moves its bytes through the byte-wide store port (a colour entry is served from
// the map without the store); each further light of a list adds a walk through the pool.
// After reset a clearing pass over max(VIRTUAL_LIGHTS, STORE_BYTES) addresses of the map and
// the store runs before the first request is taken. A stalled result holds the next request
// off; configuration is taken.
module led_virtual_pixel_mapper_top import lvpm_pkg::*; #(
  parameter int VIRTUAL_LIGHTS = 4096,
  parameter int POOL_ENTRIES   = 4096,
  parameter int STORE_BYTES    = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // virtual_index, physical_index, channel_offset, byte_count, byte0..byte3, zero pad
  input  logic [79:0] in_tdata,
  // command
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read0, read1, read2
  output logic [23:0] out_tdata,
  // status
  output logic [1:0]  out_tuser,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  // channels_per_light, zero pad
  input  logic [7:0]  cfg_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_tready = 1'b1;

  lvpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lvpm_dp #(
    .VIRTUAL_LIGHTS (VIRTUAL_LIGHTS),
    .POOL_ENTRIES   (POOL_ENTRIES),
    .STORE_BYTES    (STORE_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tdata  (cfg_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ rtl/lvpm_ctrl.sv @@
// Sequencing state machine of the virtual light mapper.
module lvpm_ctrl import lvpm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DEC   = 5'd2;
  localparam logic [4:0] S_CLR   = 5'd3;
  localparam logic [4:0] S_EVAL  = 5'd4;
  localparam logic [4:0] S_NEW2  = 5'd5;
  localparam logic [4:0] S_APP1  = 5'd6;
  localparam logic [4:0] S_APP2  = 5'd7;
  localparam logic [4:0] S_PTR   = 5'd8;
  localparam logic [4:0] S_POOL  = 5'd9;
  localparam logic [4:0] S_LIGHT = 5'd10;
  localparam logic [4:0] S_MUL   = 5'd11;
  localparam logic [4:0] S_ADDR  = 5'd12;
  localparam logic [4:0] S_CHK   = 5'd13;
  localparam logic [4:0] S_WR    = 5'd14;
  localparam logic [4:0] S_RD    = 5'd15;
  localparam logic [4:0] S_AFTER = 5'd16;

  logic [4:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE) && stat_i.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd_o = '{op: OP_NONE, fin: 1'b0, fin_status: ST_DONE};
    case (state_r)
      S_INIT: begin
        cmd_o.op = OP_INIT_STEP;
        if (stat_i.init_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd_o.op = OP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (stat_i.cmd)
          CMD_CLEAR: begin
            cmd_o.op = OP_CLR_START;
            state_nxt = S_CLR;
          end
          CMD_ADD: begin
            if (stat_i.v_range) begin
              cmd_o.fin = 1'b1;
              cmd_o.fin_status = ST_RANGE;
              state_nxt = S_IDLE;
            end else begin
              cmd_o.op = OP_ENT_RD;
              state_nxt = S_EVAL;
            end
          end
          default: begin
            if (stat_i.cmd == CMD_WRITE && stat_i.cnt_bad) begin
              cmd_o.fin = 1'b1;
              cmd_o.fin_status = ST_RANGE;
              state_nxt = S_IDLE;
            end else if (!stat_i.mapped) begin
              cmd_o.op = OP_LIGHT_V;
              state_nxt = S_MUL;
            end else begin
              cmd_o.op = OP_ENT_RD;
              state_nxt = S_EVAL;
            end
          end
        endcase
      end
      S_CLR: begin
        cmd_o.op = OP_CLR_STEP;
        if (stat_i.clr_done) begin
          cmd_o.fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EVAL: begin
        if (stat_i.cmd == CMD_ADD) begin
          case (stat_i.kind)
            KIND_COLOR: begin
              cmd_o.op = OP_ADD_COLOR;
              cmd_o.fin = 1'b1;
              state_nxt = S_IDLE;
            end
            KIND_ONE: begin
              if (stat_i.full_new) begin
                cmd_o.fin = 1'b1;
                cmd_o.fin_status = ST_FULL;
                state_nxt = S_IDLE;
              end else begin
                cmd_o.op = OP_ADD_NEW1;
                state_nxt = S_NEW2;
              end
            end
            default: begin
              if (stat_i.full_app) begin
                cmd_o.fin = 1'b1;
                cmd_o.fin_status = ST_FULL;
                state_nxt = S_IDLE;
              end else begin
                cmd_o.op = OP_HT_RD;
                state_nxt = S_APP1;
              end
            end
          endcase
        end else begin
          case (stat_i.kind)
            KIND_COLOR: begin
              cmd_o.op = (stat_i.cmd == CMD_READ) ? OP_COLOR_RD : OP_COLOR_WR;
              cmd_o.fin = 1'b1;
              state_nxt = S_IDLE;
            end
            KIND_ONE: begin
              cmd_o.op = OP_LIGHT_VAL;
              state_nxt = S_MUL;
            end
            default: begin
              cmd_o.op = OP_HT_RD;
              state_nxt = S_PTR;
            end
          endcase
        end
      end
      S_NEW2: begin
        cmd_o.op = OP_ADD_NEW2;
        cmd_o.fin = 1'b1;
        state_nxt = S_IDLE;
      end
      S_APP1: begin
        cmd_o.op = OP_ADD_APP1;
        state_nxt = S_APP2;
      end
      S_APP2: begin
        cmd_o.op = OP_ADD_APP2;
        cmd_o.fin = 1'b1;
        state_nxt = S_IDLE;
      end
      S_PTR: begin
        cmd_o.op = OP_PTR_HEAD;
        state_nxt = S_POOL;
      end
      S_POOL: begin
        cmd_o.op = OP_POOL_RD;
        state_nxt = S_LIGHT;
      end
      S_LIGHT: begin
        cmd_o.op = OP_LIGHT_PL;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd_o.op = OP_ADDR;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd_o.op = OP_CHK;
        if (stat_i.cmd == CMD_READ) begin
          if (stat_i.oob) begin
            cmd_o.fin = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end else begin
          state_nxt = stat_i.oob ? S_AFTER : S_WR;
        end
      end
      S_WR: begin
        if (stat_i.wr_last) state_nxt = S_AFTER;
        else cmd_o.op = OP_WBYTE;
      end
      S_RD: begin
        cmd_o.op = OP_RBYTE;
        if (stat_i.rd_last) begin
          cmd_o.fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_AFTER: begin
        if (!stat_i.list_mode || stat_i.at_tail) begin
          cmd_o.fin = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd_o.op = OP_NEXT;
          state_nxt = S_POOL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else state_r <= state_nxt;
  end

endmodule

@@ rtl/lvpm_dp.sv @@
// Datapath of the virtual light mapper: map, list pool, byte store and result register.
module lvpm_dp import lvpm_pkg::*; #(
  parameter int VIRTUAL_LIGHTS = 4096,
  parameter int POOL_ENTRIES   = 4096,
  parameter int STORE_BYTES    = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic [79:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        cfg_tvalid,
  input  logic [7:0]  cfg_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [1:0]  out_tuser
);

  localparam int VW     = $clog2(VIRTUAL_LIGHTS);
  localparam int PW     = $clog2(POOL_ENTRIES);
  localparam int SW     = $clog2(STORE_BYTES);
  localparam int INIT_N = (VIRTUAL_LIGHTS > STORE_BYTES) ? VIRTUAL_LIGHTS : STORE_BYTES;
  localparam int CW     = $clog2(INIT_N);

  logic [17:0]   ent_mem  [VIRTUAL_LIGHTS];
  logic [PW-1:0] head_mem [VIRTUAL_LIGHTS];
  logic [PW-1:0] tail_mem [VIRTUAL_LIGHTS];
  logic [15:0]   pl_mem   [POOL_ENTRIES];
  logic [PW-1:0] pn_mem   [POOL_ENTRIES];
  logic [7:0]    st_mem   [STORE_BYTES];

  logic [17:0]   ent_q_r;
  logic [PW-1:0] head_q_r, tail_q_r, pn_q_r;
  logic [15:0]   pl_q_r;
  logic [7:0]    st_q_r;

  logic [5:0]  cpl_r;
  logic [1:0]  cmd_r;
  logic [15:0] v_r, p_r, light_r;
  logic [7:0]  off_r;
  logic [2:0]  cnt_r, wi_r;
  logic [7:0]  b_r [4];
  logic [VW:0] mapped_r, list_cnt_r;
  logic [PW:0] pool_used_r;
  logic [CW-1:0] idx_r;
  logic [21:0] prod_r;
  logic [ADDR_W-1:0] addr_r;
  logic [1:0]  ri_r;
  logic [7:0]  rd_r [3];
  logic [7:0]  rd_nxt [3];
  logic        err_r, list_mode_r;
  logic [PW-1:0] ptr_r;
  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic [1:0]  out_stat_r;

  logic [1:0]    ent_kind;
  logic [15:0]   ent_val;
  logic [VW-1:0] lst;
  logic [VW-1:0] ht_wa;
  logic [PW-1:0] slot;
  logic          ent_we, pl_we, pn_we, head_we, tail_we, st_we, st_re;
  logic [VW-1:0] ent_wa;
  logic [17:0]   ent_wd;
  logic [PW-1:0] pl_wa, pn_wa, pn_wd, head_wd, tail_wd;
  logic [15:0]   pl_wd;
  logic [SW-1:0] st_wa, st_ra;
  logic [7:0]    st_wd;
  logic          oob, err_set, map_grow;
  logic [ADDR_W-1:0] addr_end;

  function automatic logic [4:0] sat_hi5(input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, b} + 9'd3;
    return s[8] ? 5'h1F : s[7:3];
  endfunction

  function automatic logic [13:0] pack_color(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, b} + 9'd7;
    return {sat_hi5(r), sat_hi5(g), (s[8] ? 4'hF : s[7:4])};
  endfunction

  assign ent_kind = ent_q_r[17:16];
  assign ent_val  = ent_q_r[15:0];
  assign lst      = ent_val[VW-1:0];
  assign ht_wa    = (cmd_i.op == OP_ADD_NEW2) ? list_cnt_r[VW-1:0] : lst;
  assign slot     = pool_used_r[PW-1:0];
  assign addr_end = addr_r + ((cmd_r == CMD_READ) ? ADDR_W'(3) : ADDR_W'(cnt_r));
  assign oob      = addr_end >= ADDR_W'(STORE_BYTES);
  assign err_set  = (cmd_i.op == OP_CHK) && oob;
  assign map_grow = ({1'b0, v_r} + 17'd1) > 17'(mapped_r);

  always_comb begin
    stat_o.out_free  = !out_valid_r || out_tready;
    stat_o.init_done = idx_r == CW'(INIT_N - 1);
    stat_o.clr_done  = idx_r == CW'(VIRTUAL_LIGHTS - 1);
    stat_o.cmd       = cmd_r;
    stat_o.v_range   = {1'b0, v_r} >= 17'(VIRTUAL_LIGHTS);
    stat_o.cnt_bad   = cnt_r > 3'd4;
    stat_o.mapped    = {1'b0, v_r} < 17'(mapped_r);
    stat_o.kind      = ent_kind;
    stat_o.full_new  = ((PW + 2)'(pool_used_r) + (PW + 2)'(2)) > (PW + 2)'(POOL_ENTRIES)
                       || (list_cnt_r >= (VW + 1)'(VIRTUAL_LIGHTS));
    stat_o.full_app  = pool_used_r >= (PW + 1)'(POOL_ENTRIES);
    stat_o.oob       = oob;
    stat_o.wr_last   = wi_r == cnt_r;
    stat_o.rd_last   = ri_r == 2'd3;
    stat_o.at_tail   = ptr_r == tail_q_r;
    stat_o.list_mode = list_mode_r;
  end

  always_comb begin
    ent_we = 1'b0; ent_wa = v_r[VW-1:0]; ent_wd = '0;
    pl_we = 1'b0; pl_wa = slot; pl_wd = p_r;
    pn_we = 1'b0; pn_wa = slot; pn_wd = '0;
    head_we = 1'b0; tail_we = 1'b0; head_wd = slot; tail_wd = slot;
    st_we = 1'b0; st_wa = SW'(addr_r[SW-1:0] + SW'(wi_r)); st_wd = b_r[wi_r[1:0]];
    st_re = 1'b0; st_ra = SW'(addr_r[SW-1:0] + SW'(ri_r));
    rd_nxt = rd_r;
    case (cmd_i.op)
      OP_LOAD: rd_nxt = '{8'd0, 8'd0, 8'd0};
      OP_INIT_STEP: begin
        ent_we = {1'b0, idx_r} < (CW + 1)'(VIRTUAL_LIGHTS);
        ent_wa = idx_r[VW-1:0];
        st_we  = {1'b0, idx_r} < (CW + 1)'(STORE_BYTES);
        st_wa  = idx_r[SW-1:0];
        st_wd  = 8'd0;
      end
      OP_CLR_STEP: begin
        ent_we = 1'b1;
        ent_wa = idx_r[VW-1:0];
      end
      OP_ADD_COLOR: begin
        ent_we = 1'b1;
        ent_wd = {KIND_ONE, p_r};
      end
      OP_ADD_NEW1: begin
        pl_we = 1'b1;
        pl_wd = ent_val;
        pn_we = 1'b1;
        pn_wd = slot + PW'(1);
      end
      OP_ADD_NEW2: begin
        pl_we = 1'b1;
        pl_wa = slot + PW'(1);
        pn_we = 1'b1;
        pn_wa = slot + PW'(1);
        head_we = 1'b1;
        tail_we = 1'b1;
        tail_wd = slot + PW'(1);
        ent_we = 1'b1;
        ent_wd = {KIND_MORE, 16'(list_cnt_r[VW-1:0])};
      end
      OP_ADD_APP1: begin
        pl_we = 1'b1;
        pn_we = 1'b1;
      end
      OP_ADD_APP2: begin
        pn_we = 1'b1;
        pn_wa = tail_q_r;
        pn_wd = slot;
        tail_we = 1'b1;
      end
      OP_COLOR_WR: begin
        ent_we = cnt_r == 3'd3;
        ent_wd = {KIND_COLOR, 2'b00, pack_color(b_r[0], b_r[1], b_r[2])};
      end
      OP_COLOR_RD: begin
        if (cpl_r == 6'd3) begin
          rd_nxt[0] = {ent_val[13:9], 3'b000};
          rd_nxt[1] = {ent_val[8:4], 3'b000};
          rd_nxt[2] = {ent_val[3:0], 4'b0000};
        end
      end
      OP_WBYTE: st_we = 1'b1;
      OP_RBYTE: begin
        st_re = ri_r != 2'd3;
        if (ri_r != 2'd0) rd_nxt[ri_r - 2'd1] = st_q_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (cmd_i.op == OP_ENT_RD) ent_q_r <= ent_mem[v_r[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[ht_wa] <= head_wd;
    if (cmd_i.op == OP_HT_RD) head_q_r <= head_mem[lst];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[ht_wa] <= tail_wd;
    if (cmd_i.op == OP_HT_RD) tail_q_r <= tail_mem[lst];
  end

  always_ff @(posedge clk) begin
    if (pl_we) pl_mem[pl_wa] <= pl_wd;
    if (cmd_i.op == OP_POOL_RD) pl_q_r <= pl_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (pn_we) pn_mem[pn_wa] <= pn_wd;
    if (cmd_i.op == OP_POOL_RD) pn_q_r <= pn_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    if (st_re) st_q_r <= st_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd_i.op == OP_LOAD) begin
      cmd_r  <= in_tuser;
      v_r    <= in_tdata[15:0];
      p_r    <= in_tdata[31:16];
      off_r  <= in_tdata[39:32];
      cnt_r  <= in_tdata[42:40];
      b_r[0] <= in_tdata[50:43];
      b_r[1] <= in_tdata[58:51];
      b_r[2] <= in_tdata[66:59];
      b_r[3] <= in_tdata[74:67];
    end
    case (cmd_i.op)
      OP_LIGHT_V:   light_r <= v_r;
      OP_LIGHT_VAL: light_r <= ent_val;
      OP_LIGHT_PL:  light_r <= pl_q_r;
      OP_MUL:       prod_r  <= 22'(light_r) * 22'(cpl_r);
      OP_ADDR:      addr_r  <= ADDR_W'(prod_r) + ADDR_W'(off_r);
      OP_PTR_HEAD:  ptr_r   <= head_q_r;
      OP_NEXT:      ptr_r   <= pn_q_r;
      default: ;
    endcase
    rd_r <= rd_nxt;
    if (cmd_i.fin) begin
      out_data_r <= {rd_nxt[2], rd_nxt[1], rd_nxt[0]};
      out_stat_r <= (cmd_i.fin_status == ST_DONE && (err_r || err_set)) ? ST_RANGE
                    : cmd_i.fin_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpl_r       <= 6'd3;
      mapped_r    <= '0;
      list_cnt_r  <= '0;
      pool_used_r <= '0;
      idx_r       <= '0;
      wi_r        <= '0;
      ri_r        <= '0;
      err_r       <= 1'b0;
      list_mode_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_tvalid) cpl_r <= cfg_tdata[5:0];
      if (cmd_i.fin) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (cmd_i.op)
        OP_LOAD: begin
          err_r <= 1'b0;
          list_mode_r <= 1'b0;
        end
        OP_INIT_STEP, OP_CLR_STEP: idx_r <= idx_r + CW'(1);
        OP_CLR_START: begin
          idx_r <= '0;
          mapped_r <= '0;
          list_cnt_r <= '0;
          pool_used_r <= '0;
        end
        OP_ADD_COLOR: if (map_grow) mapped_r <= (VW + 1)'(v_r + 16'd1);
        OP_ADD_NEW2: begin
          if (map_grow) mapped_r <= (VW + 1)'(v_r + 16'd1);
          list_cnt_r <= list_cnt_r + (VW + 1)'(1);
          pool_used_r <= pool_used_r + (PW + 1)'(2);
        end
        OP_ADD_APP2: begin
          if (map_grow) mapped_r <= (VW + 1)'(v_r + 16'd1);
          pool_used_r <= pool_used_r + (PW + 1)'(1);
        end
        OP_HT_RD: list_mode_r <= 1'b1;
        OP_ADDR: begin
          wi_r <= '0;
          ri_r <= '0;
        end
        OP_CHK: if (oob) err_r <= 1'b1;
        OP_WBYTE: wi_r <= wi_r + 3'd1;
        OP_RBYTE: ri_r <= ri_r + 2'd1;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule
